// ===== rtl/rri_pkg.sv =====
// ---------------------------------------------------------------------------
// rri_pkg - shared types and constants for the ray/rectangle slab test
// Fixed-point limits, divider geometry and the per-stage divider record.
// ---------------------------------------------------------------------------
package rri_pkg;

  localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

  // quotient bits resolved by the divider (bits 32..0)
  localparam int DIV_QBITS = 33;
  // setup stage + one stage per quotient bit + sign/saturate stage
  localparam int DIV_LAT   = DIV_QBITS + 2;

  typedef struct packed {
    logic [31:0] rem;   // partial remainder
    logic [32:0] num;   // low dividend bits still to shift in
    logic [32:0] q;     // quotient magnitude
    logic [31:0] dmag;  // divisor magnitude
    logic        neg;   // quotient sign
    logic        zero;  // divisor is zero
    logic        dpos;  // dividend > 0
    logic        dneg;  // dividend < 0
    logic        ovf;   // quotient magnitude >= 2^33
  } div_stage_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } ray_t;

endpackage

// ===== rtl/rri_div.sv =====
// ---------------------------------------------------------------------------
// rri_div - pipelined slab-time divider lane
// ((diff << 16) / dir), truncated toward zero, saturated to Q16.16;
// one quotient bit per stage; x/0 gives signed infinity, 0/0 gives zero.
// ---------------------------------------------------------------------------
module rri_div
  import rri_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] diff,
  input  logic signed [31:0] dir,
  output logic signed [31:0] quo
);

  div_stage_t st_r [0:DIV_QBITS];
  logic signed [31:0] quo_r;

  // setup: magnitudes, sign, early overflow check
  logic [33:0] nmag;
  logic [31:0] dmag;
  div_stage_t  st0_nxt;

  always_comb begin
    nmag = diff[33] ? 34'(-diff) : 34'(diff);
    dmag = dir[31] ? 32'(-dir) : 32'(dir);
    st0_nxt.rem  = {15'd0, nmag[33:17]};
    st0_nxt.num  = {nmag[16:0], 16'd0};
    st0_nxt.q    = '0;
    st0_nxt.dmag = dmag;
    st0_nxt.neg  = diff[33] ^ dir[31];
    st0_nxt.zero = (dir == 32'sd0);
    st0_nxt.dpos = !diff[33] && (diff != 34'sd0);
    st0_nxt.dneg = diff[33];
    st0_nxt.ovf  = ({15'd0, nmag[33:17]} >= dmag);
  end

  // one restoring iteration, resolves quotient bit bi
  function automatic div_stage_t div_step(div_stage_t s, int bi);
    logic [32:0] trial;
    logic        ge;
    div_stage_t  r;
    trial = {s.rem, s.num[bi]};
    ge    = (trial >= {1'b0, s.dmag});
    r     = s;
    if (ge) begin
      r.rem = 32'(trial - {1'b0, s.dmag});
    end else begin
      r.rem = trial[31:0];
    end
    r.q[bi] = ge;
    return r;
  endfunction

  // restoring iterations, MSB first
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_nxt;
      for (int k = 0; k < DIV_QBITS; k++) begin
        st_r[k+1] <= div_step(st_r[k], DIV_QBITS - 1 - k);
      end
    end
  end

  // sign and saturation
  div_stage_t         fin;
  logic signed [31:0] quo_nxt;

  always_comb begin
    fin = st_r[DIV_QBITS];
    if (fin.zero) begin
      if (fin.dpos) begin
        quo_nxt = FX_MAX;
      end else if (fin.dneg) begin
        quo_nxt = FX_MIN;
      end else begin
        quo_nxt = 32'sd0;
      end
    end else if (fin.neg) begin
      if (fin.ovf || fin.q > 33'h0_8000_0000) begin
        quo_nxt = FX_MIN;
      end else begin
        quo_nxt = 32'(-fin.q);
      end
    end else begin
      if (fin.ovf || fin.q > 33'h0_7FFF_FFFF) begin
        quo_nxt = FX_MAX;
      end else begin
        quo_nxt = 32'(fin.q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

// ===== rtl/ray_rect_intersect.sv =====
// ---------------------------------------------------------------------------
// ray_rect_intersect - 2D ray versus axis-aligned rectangle, slab test
// Signed Q16.16 ray/rectangle in, hit flag, near time, contact and normal out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one beat carries a ray (origin, direction) and a
//   rectangle (low corner, size). Accepted when in_valid && !in_stall.
//   Output channel out_*: one result beat per input beat, in order, taken
//   when out_valid && !out_stall.
//   Pipeline: 39 register stages (input register, 35-stage divider lanes,
//   sort/compare, multiply, contact add/saturate); out_valid is registered
//   with the result beat in the final stage.
//   Throughput: one beat per cycle unless out_* stalls. Four divider lanes
//   (one per slab edge) resolve one quotient bit per stage, which sets the depth.
//   Stall: the whole pipe freezes while a result sits unaccepted on out_*;
//   in_stall follows the same condition, so nothing is dropped or repeated.
//   Reset (rst_n low, synchronous): all valid bits clear; payload registers
//   are left as they are. No configuration and no state across beats.
//   A miss reports hit=0 with time, contact and normal all zero; a tie in
//   entry times gives a zero normal.
// ---------------------------------------------------------------------------
module ray_rect_intersect
  import rri_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_ray_pos_x,
  input  logic signed [31:0] in_ray_pos_y,
  input  logic signed [31:0] in_ray_dir_x,
  input  logic signed [31:0] in_ray_dir_y,
  input  logic signed [31:0] in_rect_x,
  input  logic signed [31:0] in_rect_y,
  input  logic        [30:0] in_rect_w,
  input  logic        [30:0] in_rect_h,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_hit_time,
  output logic signed [31:0] out_contact_x,
  output logic signed [31:0] out_contact_y,
  output logic signed [1:0]  out_normal_x,
  output logic signed [1:0]  out_normal_y
);

  localparam int NST = DIV_LAT + 4;   // A + divider + B + C + D

  localparam logic signed [1:0] NRM_POS  = 2'sb01;
  localparam logic signed [1:0] NRM_NEG  = 2'sb11;
  localparam logic signed [1:0] NRM_NONE = 2'sb00;

  // global advance: freeze everything while the output beat waits
  logic en;
  logic [NST-1:0] vld_r;

  assign en       = !(vld_r[NST-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // ---- stage A: input register
  ray_t               a_ray_r;
  logic signed [31:0] a_rx_r, a_ry_r;
  logic        [30:0] a_w_r, a_h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_ray_r.px <= in_ray_pos_x;
      a_ray_r.py <= in_ray_pos_y;
      a_ray_r.dx <= in_ray_dir_x;
      a_ray_r.dy <= in_ray_dir_y;
      a_rx_r     <= in_rect_x;
      a_ry_r     <= in_rect_y;
      a_w_r      <= in_rect_w;
      a_h_r      <= in_rect_h;
    end
  end

  // edge differences, exact at 34 bits
  logic signed [33:0] dlx, dhx, dly, dhy;
  always_comb begin
    dlx = 34'(a_rx_r) - 34'(a_ray_r.px);
    dhx = 34'(a_rx_r) + $signed({3'b000, a_w_r}) - 34'(a_ray_r.px);
    dly = 34'(a_ry_r) - 34'(a_ray_r.py);
    dhy = 34'(a_ry_r) + $signed({3'b000, a_h_r}) - 34'(a_ray_r.py);
  end

  // ---- slab time lanes
  logic signed [31:0] t_lx, t_hx, t_ly, t_hy;

  rri_div u_div_lx (.clk, .en, .diff(dlx), .dir(a_ray_r.dx), .quo(t_lx));
  rri_div u_div_hx (.clk, .en, .diff(dhx), .dir(a_ray_r.dx), .quo(t_hx));
  rri_div u_div_ly (.clk, .en, .diff(dly), .dir(a_ray_r.dy), .quo(t_ly));
  rri_div u_div_hy (.clk, .en, .diff(dhy), .dir(a_ray_r.dy), .quo(t_hy));

  // ray delay line alongside the dividers
  ray_t dly_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= a_ray_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // ---- stage B: order slab times, hit test, normal
  logic signed [31:0] nx, fx, ny, fy, tnear_nxt, tfar;
  logic               hit_nxt;
  logic signed [1:0]  nmx_nxt, nmy_nxt;
  ray_t               b_ray;

  always_comb begin
    b_ray = dly_r[DIV_LAT-1];
    nx = (t_lx > t_hx) ? t_hx : t_lx;
    fx = (t_lx > t_hx) ? t_lx : t_hx;
    ny = (t_ly > t_hy) ? t_hy : t_ly;
    fy = (t_ly > t_hy) ? t_ly : t_hy;
    tnear_nxt = (nx > ny) ? nx : ny;
    tfar      = (fx < fy) ? fx : fy;
    hit_nxt   = !(nx > fy || ny > fx) && !(tfar < 32'sd0);
    nmx_nxt   = NRM_NONE;
    nmy_nxt   = NRM_NONE;
    if (nx > ny) begin
      nmx_nxt = b_ray.dx[31] ? NRM_POS : NRM_NEG;
    end else if (nx < ny) begin
      nmy_nxt = b_ray.dy[31] ? NRM_POS : NRM_NEG;
    end
  end

  ray_t               b_ray_r;
  logic               b_hit_r;
  logic signed [31:0] b_tnear_r;
  logic signed [1:0]  b_nmx_r, b_nmy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_ray_r   <= b_ray;
      b_hit_r   <= hit_nxt;
      b_tnear_r <= tnear_nxt;
      b_nmx_r   <= nmx_nxt;
      b_nmy_r   <= nmy_nxt;
    end
  end

  // ---- stage C: dir * near
  logic signed [63:0] c_prx_r, c_pry_r;
  logic signed [31:0] c_px_r, c_py_r, c_tnear_r;
  logic               c_hit_r;
  logic signed [1:0]  c_nmx_r, c_nmy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_prx_r   <= b_ray_r.dx * b_tnear_r;
      c_pry_r   <= b_ray_r.dy * b_tnear_r;
      c_px_r    <= b_ray_r.px;
      c_py_r    <= b_ray_r.py;
      c_tnear_r <= b_tnear_r;
      c_hit_r   <= b_hit_r;
      c_nmx_r   <= b_nmx_r;
      c_nmy_r   <= b_nmy_r;
    end
  end

  // ---- stage D: floor to Q16.16, add origin, saturate, mask a miss
  logic signed [48:0] sum_x, sum_y;
  logic signed [31:0] cx, cy;

  always_comb begin
    // dropping the low 16 bits of the signed product floors it
    sum_x = 49'(c_px_r) + 49'($signed(c_prx_r[63:16]));
    sum_y = 49'(c_py_r) + 49'($signed(c_pry_r[63:16]));
    if (sum_x > 49'(FX_MAX)) begin
      cx = FX_MAX;
    end else if (sum_x < 49'(FX_MIN)) begin
      cx = FX_MIN;
    end else begin
      cx = sum_x[31:0];
    end
    if (sum_y > 49'(FX_MAX)) begin
      cy = FX_MAX;
    end else if (sum_y < 49'(FX_MIN)) begin
      cy = FX_MIN;
    end else begin
      cy = sum_y[31:0];
    end
  end

  logic               d_hit_r;
  logic signed [31:0] d_time_r, d_cx_r, d_cy_r;
  logic signed [1:0]  d_nmx_r, d_nmy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_hit_r  <= c_hit_r;
      d_time_r <= c_hit_r ? c_tnear_r : 32'sd0;
      d_cx_r   <= c_hit_r ? cx : 32'sd0;
      d_cy_r   <= c_hit_r ? cy : 32'sd0;
      d_nmx_r  <= c_hit_r ? c_nmx_r : NRM_NONE;
      d_nmy_r  <= c_hit_r ? c_nmy_r : NRM_NONE;
    end
  end

  assign out_valid     = vld_r[NST-1];
  assign out_hit       = d_hit_r;
  assign out_hit_time  = d_time_r;
  assign out_contact_x = d_cx_r;
  assign out_contact_y = d_cy_r;
  assign out_normal_x  = d_nmx_r;
  assign out_normal_y  = d_nmy_r;

  // ---- checks
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_time == 32'sd0 && out_contact_x == 32'sd0 &&
      out_contact_y == 32'sd0 && out_normal_x == NRM_NONE && out_normal_y == NRM_NONE)
    else $error("miss result carries nonzero fields");

  a_one_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x == NRM_NONE || out_normal_y == NRM_NONE)
    else $error("normal points at two faces");

  a_nrm_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x != 2'sb10 && out_normal_y != 2'sb10)
    else $error("normal component out of range");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r) && $stable(b_tnear_r))
    else $error("pipe moved while output stalled");

endmodule

// ===== sim/ray_rect_checker.sv =====
// ----------------------------------------------------------------------------
// ray_rect_checker - slab-test predictor and result scoreboard
// Watches both channels of ray_rect_intersect, computes the expected hit,
// time, contact point and normal for every accepted input beat and compares
// each accepted result beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module ray_rect_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_ray_pos_x,
  input  logic signed [31:0] in_ray_pos_y,
  input  logic signed [31:0] in_ray_dir_x,
  input  logic signed [31:0] in_ray_dir_y,
  input  logic signed [31:0] in_rect_x,
  input  logic signed [31:0] in_rect_y,
  input  logic        [30:0] in_rect_w,
  input  logic        [30:0] in_rect_h,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic signed [31:0] out_hit_time,
  input  logic signed [31:0] out_contact_x,
  input  logic signed [31:0] out_contact_y,
  input  logic signed [1:0]  out_normal_x,
  input  logic signed [1:0]  out_normal_y,
  output int                 fail_count,
  output int                 pending,
  output int                 hits_seen,
  output int                 results_seen
);

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [1:0]  nx;
    logic signed [1:0]  ny;
  } isect_t;

  isect_t expected_isects[$];

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  function automatic longint clamp32(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  // SV '/' truncates toward zero, as required
  function automatic longint edge_time(longint diff, longint dir);
    if (dir == 0) begin
      if (diff > 0) return QMAX;
      if (diff < 0) return QMIN;
      return 0;
    end
    return clamp32((diff * 65536) / dir);
  endfunction

  function automatic isect_t predict_isect(
    longint px, longint py, longint dx, longint dy,
    longint rx, longint ry, longint w, longint h);
    isect_t r;
    longint tnx, tfx, tny, tfy, tmp, tn, tf, prod_x, prod_y;
    r = '0;
    tnx = edge_time(rx - px, dx);
    tfx = edge_time(rx + w - px, dx);
    tny = edge_time(ry - py, dy);
    tfy = edge_time(ry + h - py, dy);
    if (tnx > tfx) begin tmp = tnx; tnx = tfx; tfx = tmp; end
    if (tny > tfy) begin tmp = tny; tny = tfy; tfy = tmp; end
    if (tnx > tfy || tny > tfx) return r;
    tn = (tnx > tny) ? tnx : tny;
    tf = (tfx < tfy) ? tfx : tfy;
    if (tf < 0) return r;
    prod_x = dx * tn;             // fits in 63 bits; >>> floors
    prod_y = dy * tn;
    r.hit = 1'b1;
    r.t   = tn[31:0];
    r.cx  = 32'(clamp32(px + (prod_x >>> 16)));
    r.cy  = 32'(clamp32(py + (prod_y >>> 16)));
    if (tnx > tny) r.nx = (dx < 0) ? 2'sd1 : -2'sd1;
    else if (tnx < tny) r.ny = (dy < 0) ? 2'sd1 : -2'sd1;
    return r;
  endfunction

  assign pending = expected_isects.size();

  always @(posedge clk) begin
    isect_t exp_r, got;
    if (!rst_n) begin
      fail_count   <= 0;
      hits_seen    <= 0;
      results_seen <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_isects.push_back(predict_isect(in_ray_pos_x, in_ray_pos_y,
          in_ray_dir_x, in_ray_dir_y, in_rect_x, in_rect_y,
          longint'(in_rect_w), longint'(in_rect_h)));
      if (out_valid && !out_stall) begin
        got = {out_hit, out_hit_time, out_contact_x, out_contact_y,
               out_normal_x, out_normal_y};
        results_seen <= results_seen + 1;
        if (out_hit) hits_seen <= hits_seen + 1;
        if (expected_isects.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat: hit=%0b", out_hit);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_isects.pop_front();
          if (got !== exp_r) begin
            if (fail_count < 10) begin
              $display("mismatch: exp hit=%0b t=%0d c=(%0d,%0d) n=(%0d,%0d)",
                exp_r.hit, exp_r.t, exp_r.cx, exp_r.cy, exp_r.nx, exp_r.ny);
              $display("          got hit=%0b t=%0d c=(%0d,%0d) n=(%0d,%0d)",
                got.hit, got.t, got.cx, got.cy, got.nx, got.ny);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/ray_rect_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// ray_rect_intersect_tb - stimulus and verdict for the slab-test block
// Directed rays hit edges, corners, parallel and inside cases, then random
// rays, mostly aimed at random boxes; both sides add random gaps and stalls.
// ----------------------------------------------------------------------------
module ray_rect_intersect_tb;
  import rri_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM       = 1300;
  localparam int ONE            = 32'sh0001_0000;   // 1.0 in Q16.16

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_ray_pos_x, in_ray_pos_y, in_ray_dir_x, in_ray_dir_y;
  logic signed [31:0] in_rect_x, in_rect_y;
  logic        [30:0] in_rect_w, in_rect_h;
  logic               out_valid;
  logic               out_stall;
  logic               out_hit;
  logic signed [31:0] out_hit_time, out_contact_x, out_contact_y;
  logic signed [1:0]  out_normal_x, out_normal_y;

  int  fail_count, pending, hits_seen, results_seen;
  int  idle_cycles;
  bit  stim_done;
  bit  calm;          // stretches without any gaps on either side

  ray_rect_intersect dut (.*);

  ray_rect_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: per beat, hold stall high for a random gap (none while calm), then open.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      // wait for one beat to leave (stall stays low if next gap is 0)
      @(posedge clk iff out_valid);
    end
  end

  // Drive one beat and hold it until it is taken.
  task automatic send_query(input logic signed [31:0] px, py, dx, dy, rx, ry,
                            input logic [30:0] w, h);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_ray_pos_x <= px;
    in_ray_pos_y <= py;
    in_ray_dir_x <= dx;
    in_ray_dir_y <= dy;
    in_rect_x    <= rx;
    in_rect_y    <= ry;
    in_rect_w    <= w;
    in_rect_h    <= h;
    @(posedge clk iff !in_stall);
    @(negedge clk);
  endtask

  // Small-magnitude random value so the box is actually reachable.
  function automatic logic signed [31:0] near_val(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_random();
    logic signed [31:0] px, py, dx, dy, rx, ry;
    logic [30:0] w, h;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      // aimed query: modest coordinates, ray roughly toward the box
      rx = near_val(100 * ONE);
      ry = near_val(100 * ONE);
      w  = 31'($urandom_range(0, 40 * ONE));
      h  = 31'($urandom_range(0, 40 * ONE));
      px = near_val(200 * ONE);
      py = near_val(200 * ONE);
      dx = (rx + $signed({1'b0, w}) / 2 - px) / int'($urandom_range(1, 4));
      dy = (ry + $signed({1'b0, h}) / 2 - py) / int'($urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) dx = 0;
      else if ($urandom_range(0, 3) == 0) dy = near_val(ONE);
    end else if (mode < 8) begin
      // axis-aligned / tiny-direction cases
      rx = near_val(50 * ONE);
      ry = near_val(50 * ONE);
      w  = 31'($urandom_range(0, 20 * ONE));
      h  = 31'($urandom_range(0, 20 * ONE));
      px = near_val(80 * ONE);
      py = near_val(80 * ONE);
      dx = near_val(4);
      dy = near_val(4 * ONE);
    end else begin
      // full-range noise, exercises every bit and saturation
      px = $urandom(); py = $urandom(); dx = $urandom(); dy = $urandom();
      rx = $urandom(); ry = $urandom();
      w  = 31'($urandom()); h  = 31'($urandom());
    end
    send_query(px, py, dx, dy, rx, ry, w, h);
  endtask

  initial begin
    int n_dir;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_ray_pos_x = '0; in_ray_pos_y = '0; in_ray_dir_x = '0; in_ray_dir_y = '0;
    in_rect_x    = '0; in_rect_y    = '0; in_rect_w    = '0; in_rect_h    = '0;
    stim_done    = 1'b0;
    calm         = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: clean hits on each face, x entry versus y entry
    send_query(0, 0, ONE, ONE/4, 4*ONE, 0, 2*ONE, 2*ONE);          // left face
    send_query(10*ONE, 0, -ONE, ONE/4, 4*ONE, 0, 2*ONE, 2*ONE);     // right face
    send_query(0, 0, ONE/4, ONE, 0, 4*ONE, 2*ONE, 2*ONE);          // bottom face
    send_query(0, 10*ONE, ONE/4, -ONE, 0, 4*ONE, 2*ONE, 2*ONE);     // top face
    // diagonal corner hit: entry times tie, zero normal
    send_query(0, 0, ONE, ONE, 2*ONE, 2*ONE, ONE, ONE);
    // origin inside: negative near time
    send_query(ONE, ONE, ONE, ONE/2, 0, 0, 4*ONE, 4*ONE);
    // box behind the ray: far < 0 miss
    send_query(10*ONE, 0, ONE, 0, 0, -ONE, 2*ONE, 2*ONE);
    // plain miss, slabs do not overlap
    send_query(0, 0, ONE, 0, 4*ONE, 4*ONE, ONE, ONE);
    // zero direction: parallel inside slab, parallel outside, on the edge
    send_query(0, ONE, ONE, 0, 2*ONE, 0, 2*ONE, 2*ONE);
    send_query(0, 5*ONE, ONE, 0, 2*ONE, 0, 2*ONE, 2*ONE);
    send_query(0, 0, ONE, 0, 2*ONE, 0, 2*ONE, 2*ONE);
    send_query(0, 0, 0, 0, 0, 0, 0, 0);
    send_query(ONE, ONE, 0, 0, 0, 0, 2*ONE, 2*ONE);
    // field extremes and saturation
    send_query(FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, FX_MAX, '1, '1);
    send_query(FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN, FX_MIN, '1, '1);
    send_query(FX_MIN, 0, 1, 1, FX_MAX, 0, '1, '1);
    send_query(0, FX_MAX, -1, -1, FX_MIN, FX_MIN, '1, '1);
    send_query(-1, -1, 32'sh8000_0000, 1, 0, 0, '1, 0);
    send_query(0, 0, 1, 1, 32'sh4000_0000, 32'sh4000_0000, '1, '1);
    send_query(FX_MIN, FX_MIN, -1, -1, FX_MAX, FX_MAX, 0, 0);
    send_query(0, 0, ONE, -ONE, ONE, -3*ONE, '1, 2*ONE);

    n_dir = 21;
    for (int i = 0; i < N_RANDOM; i++) begin
      // occasional back-to-back bursts with no gaps anywhere
      if (i % 200 == 0) calm = ~calm & ($urandom_range(0, 1) == 1);
      if (i % 200 == 60) calm = 1'b0;
      send_random();
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    stim_done = 1'b1;

    wait (pending == 0);
    repeat (45) @(posedge clk);
    $display("Ran %0d directed and %0d random queries; %0d results checked, %0d hits.",
             n_dir, N_RANDOM, results_seen, hits_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", pending);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
rtl/rri_pkg.sv
rtl/rri_div.sv
rtl/ray_rect_intersect.sv
sim/ray_rect_checker.sv
sim/ray_rect_intersect_tb.sv
